// File: hw/rtl/sasg_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the stepper acceleration step generator.
package sasg_pkg;

	localparam int POSITION_BITS_DEF    = 32;
	localparam int PERIOD_FRAC_BITS_DEF = 12;

	localparam int CMD_W      = 3;
	localparam int VALUE_W    = 32;
	localparam int PERIOD_W   = 32;
	localparam int COEFF_W    = 48;
	localparam int BRAKE_W    = 40;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 48;
	localparam int OUT_DATA_W = 40;

	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ABS    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REL    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SETPOS = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DSTOP  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ESTOP  = 3'd5;

	localparam logic [CFG_ADDR_W-1:0] REG_DESIRED = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SLOWEST = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FLOOR   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_ACCEL   = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_DECEL   = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_BRAKE   = 3'd5;

	localparam logic [PERIOD_W-1:0] DESIRED_RST = 32'd20480000;
	localparam logic [PERIOD_W-1:0] SLOWEST_RST = 32'd204800000;
	localparam logic [PERIOD_W-1:0] FLOOR_RST   = 32'd73142857;
	localparam logic [COEFF_W-1:0]  ACCEL_RST   = 48'd56295;
	localparam logic [COEFF_W-1:0]  DECEL_RST   = 48'd56295;
	localparam logic [BRAKE_W-1:0]  BRAKE_RST   = 40'd2500000000;

	localparam logic [1:0] DIR_STOP = 2'b00;
	localparam logic [1:0] DIR_POS  = 2'b01;
	localparam logic [1:0] DIR_NEG  = 2'b11;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LATCH,
		DP_EXEC,
		DP_PLAN,
		DP_LOAD_SQ,
		DP_MUL,
		DP_ACC,
		DP_SQ_DONE,
		DP_DIV,
		DP_DIV_END,
		DP_CUBE_DONE,
		DP_RAMP,
		DP_FIN,
		DP_OUT
	} dp_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_PLAN,
		S_LOAD,
		S_MUL,
		S_ACC,
		S_PASS_END,
		S_DIV,
		S_DIV_END,
		S_FIN,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PASS_SQ,
		PASS_CUBE,
		PASS_PROD
	} pass_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] limb_a;
		logic       limb_b;
		logic       brake;
	} ctl_cmd_t;

	typedef struct packed {
		logic exec_step;
		logic exec_brake;
		logic plan_toward;
		logic plan_slow;
	} dp_status_t;

endpackage

// File: hw/rtl/sasg_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences the datapath for each word.
module sasg_ctrl #(
	parameter int PERIOD_FRAC_BITS = sasg_pkg::PERIOD_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  sasg_pkg::dp_status_t status,
	output sasg_pkg::ctl_cmd_t   cmd
);

	localparam int NUM_BITS = sasg_pkg::BRAKE_W + 2 * PERIOD_FRAC_BITS;
	localparam int CW       = $clog2(NUM_BITS);

	sasg_pkg::state_t state_q, state_d;
	sasg_pkg::pass_t  pass_q, pass_d;
	logic [2:0]       pair_q, pair_d;
	logic [CW-1:0]    div_cnt_q, div_cnt_d;
	logic             brake_q, brake_d;
	logic             div_q, div_d;
	logic             out_valid_q;
	logic             last_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sasg_pkg::S_IDLE;
			pass_q      <= sasg_pkg::PASS_SQ;
			pair_q      <= '0;
			div_cnt_q   <= '0;
			brake_q     <= 1'b0;
			div_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			pass_q    <= pass_d;
			pair_q    <= pair_d;
			div_cnt_q <= div_cnt_d;
			brake_q   <= brake_d;
			div_q     <= div_d;
			if (cmd.op == sasg_pkg::DP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		unique case (pass_q)
			sasg_pkg::PASS_SQ:   last_pair = (pair_q == 3'd0);
			sasg_pkg::PASS_CUBE: last_pair = (pair_q == 3'd1);
			default:             last_pair = (pair_q == 3'd5);
		endcase
	end

	always_comb begin
		state_d    = state_q;
		pass_d     = pass_q;
		pair_d     = pair_q;
		div_cnt_d  = div_cnt_q;
		brake_d    = brake_q;
		div_d      = div_q;
		s_tready   = 1'b0;
		cmd.op     = sasg_pkg::DP_NOP;
		cmd.brake  = brake_q;
		cmd.limb_b = (pass_q == sasg_pkg::PASS_PROD) ? pair_q[0] : 1'b0;
		cmd.limb_a = (pass_q == sasg_pkg::PASS_PROD) ? pair_q[2:1] : pair_q[1:0];
		unique case (state_q)
			sasg_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = sasg_pkg::DP_LATCH;
					state_d = sasg_pkg::S_EXEC;
				end
			end
			sasg_pkg::S_EXEC: begin
				cmd.op = sasg_pkg::DP_EXEC;
				if (status.exec_step) begin
					state_d = sasg_pkg::S_PLAN;
				end else if (status.exec_brake) begin
					brake_d = 1'b1;
					div_d   = 1'b1;
					state_d = sasg_pkg::S_LOAD;
				end else begin
					state_d = sasg_pkg::S_OUT;
				end
			end
			sasg_pkg::S_PLAN: begin
				cmd.op  = sasg_pkg::DP_PLAN;
				brake_d = 1'b0;
				div_d   = status.plan_toward;
				if (status.plan_toward || status.plan_slow) begin
					state_d = sasg_pkg::S_LOAD;
				end else begin
					state_d = sasg_pkg::S_FIN;
				end
			end
			sasg_pkg::S_LOAD: begin
				cmd.op  = sasg_pkg::DP_LOAD_SQ;
				pass_d  = sasg_pkg::PASS_SQ;
				pair_d  = '0;
				state_d = sasg_pkg::S_MUL;
			end
			sasg_pkg::S_MUL: begin
				cmd.op  = sasg_pkg::DP_MUL;
				state_d = sasg_pkg::S_ACC;
			end
			sasg_pkg::S_ACC: begin
				cmd.op = sasg_pkg::DP_ACC;
				if (last_pair) begin
					state_d = sasg_pkg::S_PASS_END;
				end else begin
					pair_d  = pair_q + 3'd1;
					state_d = sasg_pkg::S_MUL;
				end
			end
			sasg_pkg::S_PASS_END: begin
				pair_d = '0;
				unique case (pass_q)
					sasg_pkg::PASS_SQ: begin
						cmd.op = sasg_pkg::DP_SQ_DONE;
						if (div_q) begin
							div_cnt_d = '0;
							state_d   = sasg_pkg::S_DIV;
						end else begin
							pass_d  = sasg_pkg::PASS_CUBE;
							state_d = sasg_pkg::S_MUL;
						end
					end
					sasg_pkg::PASS_CUBE: begin
						cmd.op  = sasg_pkg::DP_CUBE_DONE;
						pass_d  = sasg_pkg::PASS_PROD;
						state_d = sasg_pkg::S_MUL;
					end
					default: begin
						cmd.op  = sasg_pkg::DP_RAMP;
						state_d = sasg_pkg::S_FIN;
					end
				endcase
			end
			sasg_pkg::S_DIV: begin
				cmd.op    = sasg_pkg::DP_DIV;
				div_cnt_d = div_cnt_q + CW'(1);
				if (div_cnt_q == CW'(NUM_BITS - 1)) begin
					state_d = sasg_pkg::S_DIV_END;
				end
			end
			sasg_pkg::S_DIV_END: begin
				cmd.op = sasg_pkg::DP_DIV_END;
				if (brake_q) begin
					state_d = sasg_pkg::S_OUT;
				end else begin
					pass_d  = sasg_pkg::PASS_CUBE;
					pair_d  = '0;
					state_d = sasg_pkg::S_MUL;
				end
			end
			sasg_pkg::S_FIN: begin
				cmd.op  = sasg_pkg::DP_FIN;
				state_d = sasg_pkg::S_OUT;
			end
			sasg_pkg::S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.op  = sasg_pkg::DP_OUT;
					state_d = sasg_pkg::S_IDLE;
				end
			end
			default: state_d = sasg_pkg::S_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// File: hw/rtl/sasg_datapath.sv
`timescale 1ns / 1ps
// Datapath: motion state, settings, limb multiplier, radix-2 divider and result register.
module sasg_datapath #(
	parameter int POSITION_BITS    = sasg_pkg::POSITION_BITS_DEF,
	parameter int PERIOD_FRAC_BITS = sasg_pkg::PERIOD_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sasg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [sasg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [sasg_pkg::CMD_W-1:0]          in_cmd,
	input  logic [sasg_pkg::VALUE_W-1:0]        in_value,
	input  sasg_pkg::ctl_cmd_t                  cmd,
	output sasg_pkg::dp_status_t                status,
	output logic [sasg_pkg::OUT_DATA_W-1:0]     out_data
);

	localparam int P        = POSITION_BITS;
	localparam int PF       = PERIOD_FRAC_BITS;
	localparam int NUM_BITS = sasg_pkg::BRAKE_W + 2 * PF;
	localparam int QW       = (NUM_BITS > 64) ? NUM_BITS : 65;
	localparam int SH       = 48 + 2 * PF;
	localparam logic [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
	localparam logic [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

	logic [sasg_pkg::PERIOD_W-1:0] desired_q, slowest_q, floor_q;
	logic [sasg_pkg::COEFF_W-1:0]  accel_q, decel_q;
	logic [sasg_pkg::BRAKE_W-1:0]  brake_num_q;

	logic [P-1:0]                  position_q, target_q;
	logic [1:0]                    dir_q;
	logic                          pin_q;
	logic [sasg_pkg::PERIOD_W-1:0] cur_q, next_q, elapsed_q;
	logic                          pulse_q, slow_q;
	logic [sasg_pkg::CMD_W-1:0]    cmd_q;
	logic [sasg_pkg::VALUE_W-1:0]  val_q;

	logic [95:0]         ma_q;
	logic [63:0]         mb_q;
	logic [159:0]        acc_q;
	logic [63:0]         prod_s1;
	logic [1:0]          sh_s1;
	logic [63:0]         sq_q;
	logic [NUM_BITS-1:0] num_q;
	logic [64:0]         rem_q;
	logic [QW-1:0]       quo_q;

	logic                 out_pulse_q, out_pin_q, out_done_q;
	logic [1:0]           out_dir_q;
	logic [31:0]          out_pos_q;

	logic                 tpos, toward, dir_neg, at_target;
	logic [P-1:0]         mag;
	logic [31:0]          elapsed_inc;
	logic                 step_due;
	logic [31:0]          mul_a, mul_b;
	logic [64:0]          rem_sh;
	logic                 rem_ge;
	logic                 round_up;
	logic [63:0]          bd;
	logic [63:0]          delta;
	logic [31:0]          fast_next, slow_next;
	logic [63:0]          fast_diff;
	logic [64:0]          slow_sum;
	logic [32:0]          vabs;

	function automatic logic [P-1:0] add_mag(input logic [P-1:0] a, input logic neg,
		input logic [63:0] m);
		logic [P-1:0] room;
		logic [P-1:0] res;
		room = neg ? (a - POS_MIN) : (POS_MAX - a);
		if (65'(m) >= 65'(room)) begin
			res = neg ? POS_MIN : POS_MAX;
		end else begin
			res = neg ? (a - m[P-1:0]) : (a + m[P-1:0]);
		end
		return res;
	endfunction

	function automatic logic [P-1:0] clamp_v(input logic [31:0] v);
		logic signed [64:0] vx;
		logic [P-1:0]       res;
		vx = 65'($signed(v));
		if (vx > 65'($signed(POS_MAX))) begin
			res = POS_MAX;
		end else if (vx < 65'($signed(POS_MIN))) begin
			res = POS_MIN;
		end else begin
			res = P'(vx);
		end
		return res;
	endfunction

	always_comb begin
		tpos        = $signed(target_q) >= $signed(position_q);
		mag         = tpos ? (target_q - position_q) : (position_q - target_q);
		dir_neg     = (dir_q == sasg_pkg::DIR_NEG);
		toward      = ((dir_q == sasg_pkg::DIR_POS) && tpos) || (dir_neg && !tpos);
		at_target   = (position_q == target_q);
		elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 32'd1;
		step_due    = elapsed_inc >= (next_q >> PF);
		vabs        = val_q[31] ? (33'd0 - 33'($signed(val_q))) : 33'(val_q);

		status.exec_step   = (cmd_q == sasg_pkg::CMD_TICK) && (dir_q != sasg_pkg::DIR_STOP)
			&& step_due;
		status.exec_brake  = (cmd_q == sasg_pkg::CMD_DSTOP) && (dir_q != sasg_pkg::DIR_STOP);
		status.plan_toward = toward;
		status.plan_slow   = !toward && (cur_q < slowest_q);

		mul_a = ma_q[32*cmd.limb_a +: 32];
		mul_b = mb_q[32*cmd.limb_b +: 32];

		rem_sh = {rem_q[63:0], num_q[NUM_BITS-1]};
		rem_ge = rem_sh >= 65'(sq_q);

		round_up = {rem_q, 1'b0} >= 66'(sq_q);
		if ((cur_q == '0) || (|quo_q[QW-1:64])) begin
			bd = '1;
		end else if (&quo_q[63:0]) begin
			bd = quo_q[63:0];
		end else begin
			bd = quo_q[63:0] + 64'(round_up);
		end

		delta     = (|acc_q[159:SH+64]) ? '1 : acc_q[SH +: 64];
		fast_diff = 64'(cur_q) - delta;
		if (delta > 64'(cur_q)) begin
			fast_next = desired_q;
		end else begin
			fast_next = (fast_diff < 64'(desired_q)) ? desired_q : fast_diff[31:0];
		end
		slow_sum  = 65'(cur_q) + 65'(delta);
		slow_next = (slow_sum > 65'(slowest_q)) ? slowest_q : slow_sum[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q   <= sasg_pkg::DESIRED_RST;
			slowest_q   <= sasg_pkg::SLOWEST_RST;
			floor_q     <= sasg_pkg::FLOOR_RST;
			accel_q     <= sasg_pkg::ACCEL_RST;
			decel_q     <= sasg_pkg::DECEL_RST;
			brake_num_q <= sasg_pkg::BRAKE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				sasg_pkg::REG_DESIRED: desired_q   <= cfg_wdata[31:0];
				sasg_pkg::REG_SLOWEST: slowest_q   <= cfg_wdata[31:0];
				sasg_pkg::REG_FLOOR:   floor_q     <= cfg_wdata[31:0];
				sasg_pkg::REG_ACCEL:   accel_q     <= cfg_wdata;
				sasg_pkg::REG_DECEL:   decel_q     <= cfg_wdata;
				sasg_pkg::REG_BRAKE:   brake_num_q <= cfg_wdata[39:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			target_q   <= '0;
			dir_q      <= sasg_pkg::DIR_STOP;
			pin_q      <= 1'b0;
			cur_q      <= '0;
			next_q     <= '0;
			elapsed_q  <= '0;
			pulse_q    <= 1'b0;
			slow_q     <= 1'b0;
		end else begin
			case (cmd.op)
				sasg_pkg::DP_EXEC: begin
					pulse_q <= status.exec_step;
					case (cmd_q)
						sasg_pkg::CMD_TICK: begin
							if (dir_q == sasg_pkg::DIR_STOP) begin
								if (!at_target) begin
									dir_q     <= tpos ? sasg_pkg::DIR_POS : sasg_pkg::DIR_NEG;
									pin_q     <= !tpos;
									next_q    <= slowest_q;
									elapsed_q <= '0;
								end
							end else if (step_due) begin
								position_q <= add_mag(position_q, dir_neg, 64'd1);
								cur_q      <= next_q;
								elapsed_q  <= '0;
							end else begin
								elapsed_q <= elapsed_inc;
							end
						end
						sasg_pkg::CMD_ABS: target_q <= clamp_v(val_q);
						sasg_pkg::CMD_REL: target_q <= add_mag(position_q, val_q[31], 64'(vabs));
						sasg_pkg::CMD_SETPOS: position_q <= clamp_v(val_q);
						sasg_pkg::CMD_DSTOP: begin
							if (dir_q == sasg_pkg::DIR_STOP) begin
								target_q <= position_q;
							end
						end
						sasg_pkg::CMD_ESTOP: begin
							if (!((dir_q == sasg_pkg::DIR_STOP) && at_target)) begin
								cur_q    <= '0;
								next_q   <= '0;
								dir_q    <= sasg_pkg::DIR_STOP;
								target_q <= position_q;
							end
						end
						default: ;
					endcase
				end
				sasg_pkg::DP_PLAN: begin
					if (status.plan_slow) begin
						slow_q <= 1'b1;
					end else if (!toward) begin
						dir_q <= dir_neg ? sasg_pkg::DIR_POS : sasg_pkg::DIR_NEG;
						pin_q <= !dir_neg;
					end
				end
				sasg_pkg::DP_DIV_END: begin
					if (cmd.brake) begin
						target_q <= add_mag(position_q, dir_neg, bd);
					end else begin
						slow_q <= (65'(mag) < 65'(bd)) || (next_q < desired_q);
					end
				end
				sasg_pkg::DP_RAMP: next_q <= slow_q ? slow_next : fast_next;
				sasg_pkg::DP_FIN: begin
					if (at_target && (next_q >= floor_q)) begin
						cur_q  <= '0;
						next_q <= '0;
						dir_q  <= sasg_pkg::DIR_STOP;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			sasg_pkg::DP_LATCH: begin
				cmd_q <= in_cmd;
				val_q <= in_value;
			end
			sasg_pkg::DP_LOAD_SQ: begin
				ma_q  <= 96'(cur_q);
				mb_q  <= 64'(cur_q);
				acc_q <= '0;
			end
			sasg_pkg::DP_MUL: begin
				prod_s1 <= mul_a * mul_b;
				sh_s1   <= cmd.limb_a + 2'(cmd.limb_b);
			end
			sasg_pkg::DP_ACC: acc_q <= acc_q + ({96'd0, prod_s1} << {sh_s1, 5'd0});
			sasg_pkg::DP_SQ_DONE: begin
				sq_q  <= acc_q[63:0];
				ma_q  <= acc_q[95:0];
				mb_q  <= 64'(cur_q);
				acc_q <= '0;
				num_q <= NUM_BITS'(brake_num_q) << (2 * PF);
				rem_q <= '0;
				quo_q <= '0;
			end
			sasg_pkg::DP_DIV: begin
				rem_q <= rem_ge ? (rem_sh - 65'(sq_q)) : rem_sh;
				quo_q <= {quo_q[QW-2:0], rem_ge};
				num_q <= num_q << 1;
			end
			sasg_pkg::DP_CUBE_DONE: begin
				ma_q  <= acc_q[95:0];
				mb_q  <= 64'(slow_q ? decel_q : accel_q);
				acc_q <= '0;
			end
			sasg_pkg::DP_OUT: begin
				out_pulse_q <= pulse_q;
				out_pin_q   <= pin_q;
				out_dir_q   <= dir_q;
				out_pos_q   <= 32'($signed(position_q));
				out_done_q  <= (dir_q == sasg_pkg::DIR_STOP) && at_target;
			end
			default: ;
		endcase
	end

	assign out_data = {3'b000, out_done_q, out_pos_q, out_dir_q, out_pin_q, out_pulse_q};

endmodule

// File: hw/rtl/stepper_accel_step_generator_top.sv
`timescale 1ns / 1ps
// Top level of the stepper acceleration step generator.
// Each input word is a one-microsecond tick or a motion command, and yields one output word
// with the step pulse, direction pin, motion direction, position and a done flag. One word
// is processed at a time. A step tick runs the next-period planner: one shared 32 by 32
// multiplier forms the square, the cube and the coefficient product in nine limb products,
// and a radix-2 divider computes the braking distance. A step toward the target uses the
// divider, a slow-down away from it skips the divider, and a reversal skips the multiplier
// and the divider. A decelerating stop while moving forms the square and runs the divider.
// Settings must be written by the user only while the block is idle; the block does not
// enforce this.
module stepper_accel_step_generator_top #(
	parameter int POSITION_BITS    = sasg_pkg::POSITION_BITS_DEF,
	parameter int PERIOD_FRAC_BITS = sasg_pkg::PERIOD_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [sasg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [sasg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sasg_pkg::VALUE_W-1:0]     s_tdata,  // value
	input  logic [sasg_pkg::CMD_W-1:0]       s_tuser,  // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// step_pulse, direction_level, moving_direction, position_now, motion_done
	output logic [sasg_pkg::OUT_DATA_W-1:0]  m_tdata
);

	sasg_pkg::ctl_cmd_t   cmd;
	sasg_pkg::dp_status_t status;

	sasg_ctrl #(
		.PERIOD_FRAC_BITS(PERIOD_FRAC_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	sasg_datapath #(
		.POSITION_BITS   (POSITION_BITS),
		.PERIOD_FRAC_BITS(PERIOD_FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_cmd   (s_tuser),
		.in_value (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_tdata)
	);

endmodule

// File: hw/rtl/sasg_port_checker.sv
`timescale 1ns / 1ps
// Port checker for the step generator output words, bound to the top level.
module sasg_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sasg_pkg::OUT_DATA_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	a_done_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[36] |-> m_tdata[3:2] == 2'b00)
		else $error("motion done reported while moving");

	a_pin_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1] == m_tdata[3])
		else $error("direction pin disagrees with motion direction");

endmodule

bind stepper_accel_step_generator_top sasg_port_checker u_port_checker (.*);
